FILE: rtl/sorted_remap_table_unit_assert.svh
// Assertion macros for the sorted remap table unit checks.
`ifndef SORTED_REMAP_TABLE_UNIT_ASSERT_SVH
`define SORTED_REMAP_TABLE_UNIT_ASSERT_SVH

// Check a property on a given clock, disabled while reset is asserted.
`define SRT_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("sorted remap table check failed");

// Check a property on the unit's own clock and reset.
`define SRT_ASSERT(lbl, prop) \
  `SRT_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

FILE: rtl/srt_pkg.sv
// Shared types and codes of the sorted remap table unit.
`timescale 1ns / 1ps
package srt_pkg;

  localparam int unsigned CFG_W = 6;
  localparam logic [CFG_W-1:0] CAP_RESET = 6'd32;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_FLUSH  = 2'd2;

  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_ENTRY  = 2'd1;
  localparam logic [1:0] KIND_INSERT = 2'd2;
  localparam logic [1:0] KIND_FLUSH  = 2'd3;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_COLLAPSE,
    OP_SHIFT_DOWN
  } cell_op_e;

  typedef struct packed {
    logic     cmp_en;
    cell_op_e op;
  } cell_ctrl_t;

  typedef struct packed {
    logic lt;
    logic hit_any;
    logic match_any;
  } chain_t;

endpackage

FILE: rtl/srt_cell.sv
// One slot of the sorted remap table: key pair, compare flags, neighbor handoff.
`timescale 1ns / 1ps
module srt_cell #(
  parameter int unsigned ADDRESS_BITS = 40
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  srt_pkg::cell_ctrl_t     ctrl_i,
  input  logic [ADDRESS_BITS-1:0] key_i,
  input  logic [ADDRESS_BITS-1:0] req_old_i,
  input  logic [ADDRESS_BITS-1:0] req_new_i,
  input  logic                    lo_valid_i,
  input  logic [ADDRESS_BITS-1:0] lo_old_i,
  input  logic [ADDRESS_BITS-1:0] lo_new_i,
  input  srt_pkg::chain_t         lo_chain_i,
  input  logic [ADDRESS_BITS-1:0] lo_look_i,
  input  logic                    hi_valid_i,
  input  logic [ADDRESS_BITS-1:0] hi_old_i,
  input  logic [ADDRESS_BITS-1:0] hi_new_i,
  output logic                    valid_o,
  output logic [ADDRESS_BITS-1:0] old_o,
  output logic [ADDRESS_BITS-1:0] new_o,
  output srt_pkg::chain_t         chain_o,
  output logic [ADDRESS_BITS-1:0] look_o
);
  import srt_pkg::*;

  logic                    valid_q, valid_d;
  logic [ADDRESS_BITS-1:0] old_q, old_d;
  logic [ADDRESS_BITS-1:0] new_q, new_d;
  logic                    eq_old_q, eq_new_q, lt_q;
  logic                    own_lt, own_hit, own_match;

  assign own_lt    = valid_q & lt_q;
  assign own_hit   = valid_q & (eq_old_q | eq_new_q);
  assign own_match = valid_q & eq_old_q;

  assign chain_o.lt        = own_lt;
  assign chain_o.hit_any   = lo_chain_i.hit_any | own_hit;
  assign chain_o.match_any = lo_chain_i.match_any | own_match;
  assign look_o            = lo_look_i | (own_match ? new_q : '0);

  assign valid_o = valid_q;
  assign old_o   = old_q;
  assign new_o   = new_q;

  always_comb begin
    valid_d = valid_q;
    old_d   = old_q;
    new_d   = new_q;
    case (ctrl_i.op)
      OP_INSERT: begin
        if (!own_lt) begin
          if (lo_chain_i.lt) begin
            valid_d = 1'b1;
            old_d   = req_old_i;
            new_d   = req_new_i;
          end else begin
            valid_d = lo_valid_i;
            old_d   = lo_old_i;
            new_d   = lo_new_i;
          end
        end
      end
      OP_COLLAPSE: begin
        if (own_hit && !lo_chain_i.hit_any) begin
          new_d = req_new_i;
        end
      end
      OP_SHIFT_DOWN: begin
        valid_d = hi_valid_i;
        old_d   = hi_old_i;
        new_d   = hi_new_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    old_q <= old_d;
    new_q <= new_d;
    if (ctrl_i.cmp_en) begin
      eq_old_q <= (old_q == key_i);
      eq_new_q <= (new_q == key_i);
      lt_q     <= (old_q < key_i);
    end
  end

endmodule

FILE: rtl/sorted_remap_table_unit.sv
// Top level of the sorted remap table: cell chain and sequencing control.
//
//  port group          dir  transfer when
//  start_i / mode_i..  in   start_i high and busy_o low at a rising edge
//  result_valid_o ..   out  every cycle result_valid_o is high
//  cfg_we_i/cfg_wdata  in   cfg_we_i high at a rising edge
//
// Insert and lookup: compare flags load into every cell at the transfer, and the
// chain resolves and updates in the next cycle.
// A flush of N > 0 entries and an insert into a full table first stream the
// table out: the chain shifts down one cell per cycle and cell 0 drives each
// entry out; the flush or insert result follows.
// Reset clears all cell valid bits and the entry count, and sets capacity to 32.
// Results cannot be stalled; each shows for one cycle on result_valid_o.
`timescale 1ns / 1ps
module sorted_remap_table_unit #(
  parameter int unsigned TABLE_DEPTH  = 32,
  parameter int unsigned ADDRESS_BITS = 40
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [1:0]              mode_i,
  input  logic [ADDRESS_BITS-1:0] old_address_i,
  input  logic [ADDRESS_BITS-1:0] new_address_i,
  input  logic                    cfg_we_i,
  input  logic [srt_pkg::CFG_W-1:0] cfg_wdata_i,
  output logic                    result_valid_o,
  output logic [1:0]              kind_o,
  output logic [ADDRESS_BITS-1:0] entry_old_o,
  output logic [ADDRESS_BITS-1:0] entry_new_o,
  output logic                    found_o,
  output logic                    last_o
);
  import srt_pkg::*;

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned LimW = (CntW > CFG_W) ? CntW : CFG_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ACT   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]              state_q, state_d;
  logic [1:0]              mode_q;
  logic [ADDRESS_BITS-1:0] req_old_q, req_new_q;
  logic [CntW-1:0]         count_q, count_d;
  logic [CFG_W-1:0]        cap_q;
  logic [LimW-1:0]         cap_ext, eff_lim;

  logic                    res_valid_q, res_valid_d;
  logic [1:0]              kind_q, kind_d;
  logic [ADDRESS_BITS-1:0] eold_q, eold_d, enew_q, enew_d;
  logic                    found_q, found_d, last_q, last_d;

  cell_ctrl_t              ctrl;
  logic                    accept;

  logic                    c_valid [TABLE_DEPTH];
  logic [ADDRESS_BITS-1:0] c_old   [TABLE_DEPTH];
  logic [ADDRESS_BITS-1:0] c_new   [TABLE_DEPTH];
  logic [ADDRESS_BITS-1:0] c_look  [TABLE_DEPTH];
  chain_t                  c_chain [TABLE_DEPTH];

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);

  assign cap_ext = LimW'(cap_q);
  always_comb begin
    eff_lim = cap_ext;
    if (cap_ext == '0) begin
      eff_lim = LimW'(1);
    end else if (cap_ext > LimW'(TABLE_DEPTH)) begin
      eff_lim = LimW'(TABLE_DEPTH);
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      logic                    lo_valid, hi_valid;
      logic [ADDRESS_BITS-1:0] lo_old, lo_new, lo_look, hi_old, hi_new;
      chain_t                  lo_chain;

      if (gi == 0) begin : g_first
        assign lo_valid = 1'b0;
        assign lo_old   = '0;
        assign lo_new   = '0;
        assign lo_look  = '0;
        assign lo_chain = '{lt: 1'b1, hit_any: 1'b0, match_any: 1'b0};
      end else begin : g_mid
        assign lo_valid = c_valid[gi-1];
        assign lo_old   = c_old[gi-1];
        assign lo_new   = c_new[gi-1];
        assign lo_look  = c_look[gi-1];
        assign lo_chain = c_chain[gi-1];
      end

      if (gi == TABLE_DEPTH - 1) begin : g_top
        assign hi_valid = 1'b0;
        assign hi_old   = '0;
        assign hi_new   = '0;
      end else begin : g_below
        assign hi_valid = c_valid[gi+1];
        assign hi_old   = c_old[gi+1];
        assign hi_new   = c_new[gi+1];
      end

      srt_cell #(
        .ADDRESS_BITS(ADDRESS_BITS)
      ) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctrl_i     (ctrl),
        .key_i      (old_address_i),
        .req_old_i  (req_old_q),
        .req_new_i  (req_new_q),
        .lo_valid_i (lo_valid),
        .lo_old_i   (lo_old),
        .lo_new_i   (lo_new),
        .lo_chain_i (lo_chain),
        .lo_look_i  (lo_look),
        .hi_valid_i (hi_valid),
        .hi_old_i   (hi_old),
        .hi_new_i   (hi_new),
        .valid_o    (c_valid[gi]),
        .old_o      (c_old[gi]),
        .new_o      (c_new[gi]),
        .chain_o    (c_chain[gi]),
        .look_o     (c_look[gi])
      );
    end
  endgenerate

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ctrl.cmp_en = accept;
    ctrl.op     = OP_HOLD;
    res_valid_d = 1'b0;
    kind_d      = kind_q;
    eold_d      = eold_q;
    enew_d      = enew_q;
    found_d     = found_q;
    last_d      = last_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_ACT;
        end
      end
      S_ACT: begin
        state_d = S_IDLE;
        case (mode_q)
          MODE_INSERT: begin
            if (c_chain[TABLE_DEPTH-1].hit_any) begin
              ctrl.op     = OP_COLLAPSE;
              res_valid_d = 1'b1;
              kind_d      = KIND_INSERT;
              eold_d      = req_old_q;
              enew_d      = req_new_q;
              found_d     = 1'b1;
              last_d      = 1'b1;
            end else if (LimW'(count_q) >= eff_lim) begin
              state_d = S_DRAIN;
            end else begin
              ctrl.op     = OP_INSERT;
              count_d     = count_q + CntW'(1);
              res_valid_d = 1'b1;
              kind_d      = KIND_INSERT;
              eold_d      = req_old_q;
              enew_d      = req_new_q;
              found_d     = 1'b0;
              last_d      = 1'b1;
            end
          end
          MODE_LOOKUP: begin
            res_valid_d = 1'b1;
            kind_d      = KIND_LOOKUP;
            eold_d      = req_old_q;
            enew_d      = c_look[TABLE_DEPTH-1];
            found_d     = c_chain[TABLE_DEPTH-1].match_any;
            last_d      = 1'b1;
          end
          MODE_FLUSH: begin
            if (count_q == '0) begin
              res_valid_d = 1'b1;
              kind_d      = KIND_FLUSH;
              eold_d      = req_old_q;
              enew_d      = '0;
              found_d     = 1'b0;
              last_d      = 1'b1;
            end else begin
              state_d = S_DRAIN;
            end
          end
          default: begin
          end
        endcase
      end
      S_DRAIN: begin
        ctrl.op     = OP_SHIFT_DOWN;
        count_d     = count_q - CntW'(1);
        res_valid_d = 1'b1;
        kind_d      = KIND_ENTRY;
        eold_d      = c_old[0];
        enew_d      = c_new[0];
        found_d     = 1'b0;
        last_d      = 1'b0;
        if (count_q == CntW'(1)) begin
          state_d = S_ACT;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cap_q       <= CAP_RESET;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q    <= mode_i;
      req_old_q <= old_address_i;
      req_new_q <= new_address_i;
    end
    kind_q  <= kind_d;
    eold_q  <= eold_d;
    enew_q  <= enew_d;
    found_q <= found_d;
    last_q  <= last_d;
  end

  assign result_valid_o = res_valid_q;
  assign kind_o         = kind_q;
  assign entry_old_o    = eold_q;
  assign entry_new_o    = enew_q;
  assign found_o        = found_q;
  assign last_o         = last_q;

endmodule

FILE: rtl/srt_checker.sv
// Port-level checks of the sorted remap table unit, bound to the top level.
`timescale 1ns / 1ps
`include "sorted_remap_table_unit_assert.svh"
module srt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       result_valid_o,
  input logic [1:0] kind_o,
  input logic       found_o,
  input logic       last_o
);
  import srt_pkg::*;

  `SRT_ASSERT(a_accept_busy, (start_i && !busy_o) |=> busy_o)
  `SRT_ASSERT(a_last_frees, (result_valid_o && last_o) |-> !busy_o)
  `SRT_ASSERT(a_entry_keeps_busy, (result_valid_o && !last_o) |-> (busy_o && kind_o == KIND_ENTRY))
  `SRT_ASSERT(a_entry_no_found, (result_valid_o && kind_o == KIND_ENTRY) |-> (!found_o && !last_o))
  `SRT_ASSERT(a_result_after_work, result_valid_o |-> $past(busy_o))

endmodule

bind sorted_remap_table_unit srt_checker u_srt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .kind_o         (kind_o),
  .found_o        (found_o),
  .last_o         (last_o)
);

FILE: tb/sv/tb_top.sv
// Self-checking testbench of the sorted remap table unit: directed and random commands.
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned ADDR_W      = 40;
  localparam int unsigned SETTLE_CYC  = TABLE_DEPTH + 8;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] entry_old;
    logic [ADDR_W-1:0] entry_new;
    logic              found;
    logic              last;
  } remap_result_t;

  class remap_tracker;
    logic [ADDR_W-1:0]         old_tbl [TABLE_DEPTH];
    logic [ADDR_W-1:0]         new_tbl [TABLE_DEPTH];
    int unsigned               held;
    logic [srt_pkg::CFG_W-1:0] capacity;
    remap_result_t             pending[$];
    int unsigned               mismatches;

    function new();
      held       = 0;
      capacity   = srt_pkg::CAP_RESET;
      mismatches = 0;
    endfunction

    function void add_result(logic [1:0] kind, logic [ADDR_W-1:0] eold,
                             logic [ADDR_W-1:0] enew, logic found, logic last);
      remap_result_t r;
      r.kind      = kind;
      r.entry_old = eold;
      r.entry_new = enew;
      r.found     = found;
      r.last      = last;
      pending.push_back(r);
    endfunction

    function void stream_entries();
      for (int unsigned i = 0; i < held; i++) begin
        add_result(srt_pkg::KIND_ENTRY, old_tbl[i], new_tbl[i], 1'b0, 1'b0);
      end
      held = 0;
    endfunction

    function void note_command(logic [1:0] mode, logic [ADDR_W-1:0] oa,
                               logic [ADDR_W-1:0] na);
      int unsigned limit;
      int unsigned pos;
      case (mode)
        srt_pkg::MODE_INSERT: begin
          for (int unsigned i = 0; i < held; i++) begin
            if (old_tbl[i] == oa || new_tbl[i] == oa) begin
              new_tbl[i] = na;
              add_result(srt_pkg::KIND_INSERT, oa, na, 1'b1, 1'b1);
              return;
            end
          end
          limit = (capacity == 0) ? 1 : (capacity > TABLE_DEPTH) ? TABLE_DEPTH : capacity;
          if (held >= limit) stream_entries();
          pos = 0;
          while (pos < held && old_tbl[pos] < oa) pos++;
          for (int unsigned i = held; i > pos; i--) begin
            old_tbl[i] = old_tbl[i-1];
            new_tbl[i] = new_tbl[i-1];
          end
          old_tbl[pos] = oa;
          new_tbl[pos] = na;
          held++;
          add_result(srt_pkg::KIND_INSERT, oa, na, 1'b0, 1'b1);
        end
        srt_pkg::MODE_LOOKUP: begin
          for (int unsigned i = 0; i < held; i++) begin
            if (old_tbl[i] == oa) begin
              add_result(srt_pkg::KIND_LOOKUP, oa, new_tbl[i], 1'b1, 1'b1);
              return;
            end
          end
          add_result(srt_pkg::KIND_LOOKUP, oa, '0, 1'b0, 1'b1);
        end
        srt_pkg::MODE_FLUSH: begin
          stream_entries();
          add_result(srt_pkg::KIND_FLUSH, oa, '0, 1'b0, 1'b1);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [1:0] kind, logic [ADDR_W-1:0] eold,
                               logic [ADDR_W-1:0] enew, logic found, logic last);
      remap_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind=%0d old=%h new=%h found=%b last=%b",
                   kind, eold, enew, found, last);
        return;
      end
      want = pending.pop_front();
      if (kind !== want.kind || eold !== want.entry_old || enew !== want.entry_new ||
          found !== want.found || last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch exp: kind=%0d old=%h new=%h found=%b last=%b",
                   want.kind, want.entry_old, want.entry_new, want.found, want.last);
          $display("         got: kind=%0d old=%h new=%h found=%b last=%b",
                   kind, eold, enew, found, last);
        end
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      start_i;
  logic                      busy_o;
  logic [1:0]                mode_i;
  logic [ADDR_W-1:0]         old_address_i;
  logic [ADDR_W-1:0]         new_address_i;
  logic                      cfg_we_i;
  logic [srt_pkg::CFG_W-1:0] cfg_wdata_i;
  logic                      result_valid_o;
  logic [1:0]                kind_o;
  logic [ADDR_W-1:0]         entry_old_o;
  logic [ADDR_W-1:0]         entry_new_o;
  logic                      found_o;
  logic                      last_o;

  remap_tracker      tracker = new();
  logic [ADDR_W-1:0] addr_pool[$];

  sorted_remap_table_unit #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDRESS_BITS(ADDR_W)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .mode_i        (mode_i),
    .old_address_i (old_address_i),
    .new_address_i (new_address_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .result_valid_o(result_valid_o),
    .kind_o        (kind_o),
    .entry_old_o   (entry_old_o),
    .entry_new_o   (entry_new_o),
    .found_o       (found_o),
    .last_o        (last_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      tracker.check_result(kind_o, entry_old_o, entry_new_o, found_o, last_o);
  end

  task automatic drive_cmd(logic [1:0] mode, logic [ADDR_W-1:0] oa, logic [ADDR_W-1:0] na);
    int unsigned gap;
    gap = $urandom_range(0, 7);
    if (gap != 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i       <= 1'b1;
    mode_i        <= mode;
    old_address_i <= oa;
    new_address_i <= na;
    do @(posedge clk_i); while (busy_o);
    tracker.note_command(mode, oa, na);
    if (mode == srt_pkg::MODE_INSERT) begin
      addr_pool.push_back(oa);
      addr_pool.push_back(na);
      while (addr_pool.size() > 48) void'(addr_pool.pop_front());
    end
  endtask

  // drain all expected transfers, then hold off long enough for a full stream
  task automatic settle();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (tracker.pending.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_capacity(logic [srt_pkg::CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    tracker.capacity = value;
  endtask

  function automatic logic [ADDR_W-1:0] pick_address();
    logic [63:0] raw;
    if (addr_pool.size() != 0 && $urandom_range(0, 1) == 1)
      return addr_pool[$urandom_range(0, addr_pool.size() - 1)];
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return raw[ADDR_W-1:0];
    endcase
  endfunction

  task automatic run_random(int unsigned count, int unsigned flush_pct);
    int unsigned roll;
    logic [1:0]  mode;
    for (int unsigned n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < flush_pct)            mode = srt_pkg::MODE_FLUSH;
      else if (roll < flush_pct + 4)   mode = MODE_UNUSED;
      else if (roll < flush_pct + 30)  mode = srt_pkg::MODE_LOOKUP;
      else                             mode = srt_pkg::MODE_INSERT;
      drive_cmd(mode, pick_address(), pick_address());
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    mode_i        = srt_pkg::MODE_INSERT;
    old_address_i = '0;
    new_address_i = '0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);
    write_capacity(6'd32);

    drive_cmd(srt_pkg::MODE_FLUSH,  '1, '0);
    drive_cmd(srt_pkg::MODE_LOOKUP, '0, '1);
    drive_cmd(srt_pkg::MODE_INSERT, '1, '0);
    drive_cmd(srt_pkg::MODE_INSERT, '0, '1);
    drive_cmd(srt_pkg::MODE_INSERT, 40'h55_5555_5555, 40'hAA_AAAA_AAAA);
    drive_cmd(srt_pkg::MODE_INSERT, 40'hAA_AAAA_AAAA, 40'h00_0000_1234);
    drive_cmd(srt_pkg::MODE_LOOKUP, '1, '0);
    drive_cmd(srt_pkg::MODE_LOOKUP, '0, '0);
    drive_cmd(srt_pkg::MODE_LOOKUP, 40'h00_0000_1234, '0);
    drive_cmd(srt_pkg::MODE_INSERT, 40'h00_0000_1234, 40'h00_0000_9999);
    drive_cmd(srt_pkg::MODE_INSERT, '0, 40'h00_0000_0042);
    drive_cmd(MODE_UNUSED, 40'h12_3456_789A, 40'hFE_DCBA_9876);
    drive_cmd(srt_pkg::MODE_LOOKUP, '0, '0);
    drive_cmd(srt_pkg::MODE_FLUSH, 40'h0F_0F0F_0F0F, '1);
    drive_cmd(srt_pkg::MODE_LOOKUP, '1, '0);
    drive_cmd(srt_pkg::MODE_INSERT, 40'h80_0000_0000, 40'h01);
    drive_cmd(srt_pkg::MODE_INSERT, 40'h00_0000_0001, 40'h02);
    drive_cmd(srt_pkg::MODE_INSERT, 40'h40_0000_0000, 40'h03);
    settle();

    // capacity below the current count: next fresh insert streams everything
    write_capacity(6'd1);
    drive_cmd(srt_pkg::MODE_INSERT, 40'h20_0000_0000, 40'h04);
    drive_cmd(srt_pkg::MODE_INSERT, 40'h10_0000_0000, 40'h05);
    settle();
    write_capacity(6'd0);
    drive_cmd(srt_pkg::MODE_INSERT, 40'h08_0000_0000, 40'h06);
    drive_cmd(srt_pkg::MODE_INSERT, 40'h04_0000_0000, 40'h07);
    drive_cmd(srt_pkg::MODE_LOOKUP, 40'h04_0000_0000, '0);
    settle();

    write_capacity(6'd63);
    run_random(45, 0);
    settle();
    write_capacity(6'd2);
    run_random(12, 6);
    settle();
    write_capacity(6'd7);
    run_random(15, 5);
    settle();
    write_capacity(6'd40);
    run_random(40, 2);
    settle();
    write_capacity(6'd3);
    run_random(12, 8);
    settle();
    write_capacity(6'd32);
    run_random(13, 10);
    settle();

    if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
